@@ rtl/qhp40_pkg.sv @@
// ----------------------------------------------------------------------------
// qhp40_pkg - shared definitions for the 40-bit quaternion key packer
// Default parameter values, code constants, controller command codes and
// the command/status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package qhp40_pkg;

  localparam int INPUT_BITS_DEF     = 16;
  localparam int NORM_FRAC_BITS_DEF = 16;

  localparam int CODE_BITS = 12;
  localparam int CODE_MID  = 2047;
  localparam int CODE_TOP  = 11;   // top bit of the code search
  localparam int PACK_BITS = 40;

  // datapath commands
  localparam logic [3:0] OP_NONE   = 4'd0;
  localparam logic [3:0] OP_LOAD   = 4'd1;
  localparam logic [3:0] OP_SQ     = 4'd2;
  localparam logic [3:0] OP_RINIT  = 4'd3;
  localparam logic [3:0] OP_STEP   = 4'd4;
  localparam logic [3:0] OP_RSTORE = 4'd5;
  localparam logic [3:0] OP_DOT    = 4'd6;
  localparam logic [3:0] OP_FLIP   = 4'd7;
  localparam logic [3:0] OP_CSQ    = 4'd8;
  localparam logic [3:0] OP_CINIT  = 4'd9;
  localparam logic [3:0] OP_CSTORE = 4'd10;
  localparam logic [3:0] OP_OUT    = 4'd11;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic eng_last;
  } status_t;

endpackage

@@ rtl/qhp40_ctrl.sv @@
// ----------------------------------------------------------------------------
// qhp40_ctrl - sequencing controller
// Walks one word through squaring, four root searches, dot, flip and three
// code searches, then hands the result to the output register.
// ----------------------------------------------------------------------------
module qhp40_ctrl
  import qhp40_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output cmd_t    cmd,
  input  status_t status
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SQ     = 4'd1;
  localparam logic [3:0] S_RINIT  = 4'd2;
  localparam logic [3:0] S_RSTEP  = 4'd3;
  localparam logic [3:0] S_RSTORE = 4'd4;
  localparam logic [3:0] S_DOT    = 4'd5;
  localparam logic [3:0] S_FLIP   = 4'd6;
  localparam logic [3:0] S_CSQ    = 4'd7;
  localparam logic [3:0] S_CINIT  = 4'd8;
  localparam logic [3:0] S_CSTEP  = 4'd9;
  localparam logic [3:0] S_CSTORE = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;

  logic [3:0] state, state_next;
  logic [1:0] idx, idx_next;
  logic       load_out;

  assign in_stall = (state != S_IDLE);
  assign load_out = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd.op     = OP_NONE;
    cmd.idx    = idx;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          idx_next   = 2'd0;
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        cmd.op = OP_SQ;
        if (idx == 2'd3) begin
          idx_next   = 2'd0;
          state_next = S_RINIT;
        end else begin
          idx_next = idx + 2'd1;
        end
      end
      S_RINIT: begin
        cmd.op     = OP_RINIT;
        state_next = S_RSTEP;
      end
      S_RSTEP: begin
        cmd.op = OP_STEP;
        if (status.eng_last) state_next = S_RSTORE;
      end
      S_RSTORE: begin
        cmd.op = OP_RSTORE;
        if (idx == 2'd3) begin
          idx_next   = 2'd0;
          state_next = S_DOT;
        end else begin
          idx_next   = idx + 2'd1;
          state_next = S_RINIT;
        end
      end
      S_DOT: begin
        cmd.op = OP_DOT;
        if (idx == 2'd3) begin
          idx_next   = 2'd0;
          state_next = S_FLIP;
        end else begin
          idx_next = idx + 2'd1;
        end
      end
      S_FLIP: begin
        cmd.op     = OP_FLIP;
        state_next = S_CSQ;
      end
      S_CSQ: begin
        cmd.op     = OP_CSQ;
        state_next = S_CINIT;
      end
      S_CINIT: begin
        cmd.op     = OP_CINIT;
        state_next = S_CSTEP;
      end
      S_CSTEP: begin
        cmd.op = OP_STEP;
        if (status.eng_last) state_next = S_CSTORE;
      end
      S_CSTORE: begin
        cmd.op = OP_CSTORE;
        if (idx == 2'd2) begin
          idx_next   = 2'd0;
          state_next = S_DONE;
        end else begin
          idx_next   = idx + 2'd1;
          state_next = S_CSQ;
        end
      end
      S_DONE: begin
        if (load_out) begin
          cmd.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (load_out)       out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule

@@ rtl/qhp40_dp.sv @@
// ----------------------------------------------------------------------------
// qhp40_dp - arithmetic datapath
// Squares, a shared shift-add square-root search (one bit per cycle), the
// dot accumulator, hemisphere flip, previous-key store and code packing.
// ----------------------------------------------------------------------------
module qhp40_dp
  import qhp40_pkg::*;
#(
  parameter int INPUT_BITS     = INPUT_BITS_DEF,
  parameter int NORM_FRAC_BITS = NORM_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic signed [INPUT_BITS-1:0] comp_x,
  input  logic signed [INPUT_BITS-1:0] comp_y,
  input  logic signed [INPUT_BITS-1:0] comp_z,
  input  logic signed [INPUT_BITS-1:0] comp_w,
  input  logic                         first_key,
  input  cmd_t                         cmd,
  output status_t                      status,
  output logic [PACK_BITS-1:0]         packed_word,
  output logic                         flipped
);

  localparam int IB  = INPUT_BITS;
  localparam int F   = NORM_FRAC_BITS;
  localparam int SQW = 2 * IB;
  localparam int LW  = 2 * IB + 2;
  localparam int W   = 2 * F + LW + 3;
  localparam int MW  = F + 1;
  localparam int BW  = $clog2(MW);
  localparam int KW  = F + 2;
  localparam int DW  = 2 * KW + 2;
  localparam int CW  = 2 * F + 2;

  logic [IB-1:0]         cin [4];
  logic [IB-1:0]         mag [4];
  logic [3:0]            neg;
  logic                  first;
  logic [SQW-1:0]        sq [4];
  logic [LW-1:0]         len2;
  logic [W-1:0]          p, r, d, tgt;
  logic [MW-1:0]         m;
  logic [BW-1:0]         bitp;
  logic signed [KW-1:0]  key [4];
  logic signed [KW-1:0]  prev [4];
  logic signed [DW-1:0]  dot;
  logic [CW-1:0]         sqc;
  logic                  negc;
  logic [CODE_BITS-1:0]  code [3];
  logic                  flip_r;

  logic [F:0]            kabs [4];
  logic [1:0]            lg;
  logic [F:0]            best;
  logic [1:0]            csel;
  logic [W-1:0]          trial;
  logic                  take;
  logic [SQW-1:0]        sq_mul;
  logic signed [DW-1:0]  dot_prod;
  logic [CW-1:0]         sqc_mul;
  logic signed [KW-1:0]  key_pos, key_one;
  logic                  flip_now;
  logic [CODE_BITS-1:0]  t_cap;

  assign cin[0] = comp_x;
  assign cin[1] = comp_y;
  assign cin[2] = comp_z;
  assign cin[3] = comp_w;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      kabs[i] = key[i][KW-1] ? (F+1)'(0) - key[i][F:0] : key[i][F:0];
    end
  end

  // largest magnitude, ties to the lowest index
  always_comb begin
    lg   = 2'd0;
    best = kabs[0];
    for (int i = 1; i < 4; i++) begin
      if (kabs[i] > best) begin
        lg   = 2'(i);
        best = kabs[i];
      end
    end
  end

  assign csel     = (cmd.idx >= lg) ? cmd.idx + 2'd1 : cmd.idx;
  assign trial    = p + r + d;
  assign take     = (trial <= tgt);
  assign sq_mul   = SQW'(mag[cmd.idx]) * SQW'(mag[cmd.idx]);
  assign dot_prod = DW'(prev[cmd.idx]) * DW'(key[cmd.idx]);
  assign sqc_mul  = CW'(kabs[csel]) * CW'(kabs[csel]);
  assign key_pos  = $signed({1'b0, m});
  assign key_one  = $signed({2'b01, F'(0)});
  assign flip_now = first ? key[3][KW-1] : dot[DW-1];
  assign t_cap    = m[CODE_BITS-1] ? CODE_BITS'(CODE_MID) : m[CODE_BITS-1:0];

  assign status.eng_last = (bitp == '0);

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        for (int i = 0; i < 4; i++) begin
          neg[i] <= cin[i][IB-1];
          mag[i] <= cin[i][IB-1] ? IB'(0) - cin[i] : cin[i];
        end
        first <= first_key;
        len2  <= '0;
        dot   <= '0;
      end
      OP_SQ: begin
        sq[cmd.idx] <= sq_mul;
        len2        <= len2 + LW'(sq_mul);
      end
      OP_RINIT: begin
        p    <= '0;
        r    <= '0;
        d    <= W'(len2) << (2 * F);
        tgt  <= W'(sq[cmd.idx]) << (2 * F);
        m    <= '0;
        bitp <= BW'(F);
      end
      OP_STEP: begin
        if (take) begin
          p <= trial;
          r <= (r + (d << 1)) >> 1;
        end else begin
          r <= r >> 1;
        end
        d       <= d >> 2;
        m[bitp] <= take;
        bitp    <= bitp - BW'(1);
      end
      OP_RSTORE: begin
        if (len2 == '0) key[cmd.idx] <= (cmd.idx == 2'd3) ? key_one : '0;
        else if (neg[cmd.idx]) key[cmd.idx] <= -key_pos;
        else key[cmd.idx] <= key_pos;
      end
      OP_DOT: begin
        dot <= dot + dot_prod;
      end
      OP_FLIP: begin
        flip_r <= flip_now;
        for (int i = 0; i < 4; i++) begin
          if (flip_now) key[i] <= -key[i];
        end
      end
      OP_CSQ: begin
        sqc  <= sqc_mul;
        negc <= key[csel][KW-1];
      end
      OP_CINIT: begin
        // target = sqc * 2 * 2047^2 = sqc * (2^23 - 2^13 + 2)
        p    <= '0;
        r    <= '0;
        d    <= W'(1) << (2 * F + 2 * CODE_TOP);
        tgt  <= (W'(sqc) << 23) - (W'(sqc) << 13) + (W'(sqc) << 1);
        m    <= '0;
        bitp <= BW'(CODE_TOP);
      end
      OP_CSTORE: begin
        code[cmd.idx] <= negc ? CODE_BITS'(CODE_MID) - t_cap
                              : CODE_BITS'(CODE_MID) + t_cap;
      end
      OP_OUT: begin
        packed_word <= {1'b0, key[lg][KW-1], lg, code[2], code[1], code[0]};
        flipped     <= flip_r;
      end
      default: begin
      end
    endcase
  end

  // previous key: stored after the flip decision
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) prev[i] <= '0;
    end else if (cmd.op == OP_FLIP) begin
      for (int i = 0; i < 4; i++) prev[i] <= flip_now ? -key[i] : key[i];
    end
  end

endmodule

@@ rtl/quaternion_hemisphere_pack40.sv @@
// ----------------------------------------------------------------------------
// quaternion_hemisphere_pack40 - rotation key hemisphere fix and 40-bit pack
// Normalizes each key, keeps it on the hemisphere of the previous one and
// packs it smallest-three into a 40-bit word.
// ----------------------------------------------------------------------------
// One word is in work at a time; the next word can be accepted in the cycle
// after the result register is loaded, and acceptance waits longer if the
// output stalls. Each word runs through the shared bit-serial square-root
// search: one result bit per cycle, NORM_FRAC_BITS+1 bits for each of the
// four normalized components and 12 bits for each of the three codes, plus
// squaring, dot accumulation and hand-off steps. in_stall stays high from
// acceptance until the result is loaded; a new word is taken while the
// previous result still waits in the output register. A zero-length key
// becomes identity; the previous key resets to zero, so a continuing key
// right after reset is not flipped.
module quaternion_hemisphere_pack40
  import qhp40_pkg::*;
#(
  parameter int INPUT_BITS     = INPUT_BITS_DEF,
  parameter int NORM_FRAC_BITS = NORM_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [INPUT_BITS-1:0] comp_x,
  input  logic signed [INPUT_BITS-1:0] comp_y,
  input  logic signed [INPUT_BITS-1:0] comp_z,
  input  logic signed [INPUT_BITS-1:0] comp_w,
  input  logic                         first_key,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [PACK_BITS-1:0]         packed_word,
  output logic                         flipped
);

  cmd_t    cmd;
  status_t status;

  // sequencer: owns the handshakes and the step order
  qhp40_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // arithmetic, previous-key store and output payload register
  qhp40_dp #(
    .INPUT_BITS     (INPUT_BITS),
    .NORM_FRAC_BITS (NORM_FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .comp_x      (comp_x),
    .comp_y      (comp_y),
    .comp_z      (comp_z),
    .comp_w      (comp_w),
    .first_key   (first_key),
    .cmd         (cmd),
    .status      (status),
    .packed_word (packed_word),
    .flipped     (flipped)
  );

endmodule

@@ rtl/qhp40_checker.sv @@
// ----------------------------------------------------------------------------
// qhp40_checker - port-level checks for the 40-bit key packer
// Watches the top-level handshakes and output word over time.
// ----------------------------------------------------------------------------
module qhp40_checker
  import qhp40_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [PACK_BITS-1:0] packed_word,
  input logic                 flipped
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(packed_word) && $stable(flipped))
    else $error("stalled result changed");

  // top bit of the packed word is always clear
  a_top_bit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !packed_word[PACK_BITS-1])
    else $error("packed word bit 39 set");

  // an accepted word keeps the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block not busy after accept");

  // going idle again means a result was just presented
  a_idle_result: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(in_stall) |-> out_valid)
    else $error("block went idle with no result");

endmodule

bind quaternion_hemisphere_pack40 qhp40_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .packed_word (packed_word),
  .flipped     (flipped)
);

@@ tb/sv/quaternion_hemisphere_pack40_tb.sv @@
// ----------------------------------------------------------------------------
// quaternion_hemisphere_pack40_tb - self-checking bench for the key packer
// Drives rotation keys through valid/stall handshakes under several idle and
// stall mixes, predicts each 40-bit packed word and flip bit in exact integer
// arithmetic, and compares every result in order against the prediction.
// ----------------------------------------------------------------------------
module quaternion_hemisphere_pack40_tb;
  import qhp40_pkg::*;

  localparam int IB = INPUT_BITS_DEF;
  localparam int FB = NORM_FRAC_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD = 1500;

  typedef struct {
    logic [PACK_BITS-1:0] word;
    logic                 flip;
  } packed_key_t;

  typedef struct {
    logic signed [IB-1:0] c [4];
    logic                 first;
  } raw_key_t;

  // Keeps the hemisphere state, the queue of predicted words and the error
  // tally.
  class key_scoreboard;
    longint      prev_key [4];
    packed_key_t pending_words [$];
    int          mismatches;

    function new();
      foreach (prev_key[i]) prev_key[i] = 0;
      mismatches = 0;
    endfunction

    // floor(|c| * 2^FB / sqrt(len2)) by a bit-serial search
    function automatic longint unit_mag(longint mag, logic [127:0] len2);
      logic [127:0] rhs, m, cand;
      rhs = (128'(mag) * 128'(mag)) << (2 * FB);
      m = 0;
      for (int b = FB; b >= 0; b--) begin
        cand = m | (128'(1) << b);
        if (len2 * cand * cand <= rhs) m = cand;
      end
      return longint'(m);
    endfunction

    // 12-bit code: 2047 +- floor(|n| * 2047 * sqrt(2) / 2^FB), capped
    function automatic logic [CODE_BITS-1:0] code_for(longint n);
      logic [127:0] rhs, lhs, t, cand;
      longint mag, code;
      mag = n < 0 ? -n : n;
      rhs = ((128'(2047) * 128'(mag)) * (128'(2047) * 128'(mag))) << 1;
      t = 0;
      for (int b = CODE_TOP; b >= 0; b--) begin
        cand = t | (128'(1) << b);
        lhs = cand << FB;
        if (lhs * lhs <= rhs) t = cand;
      end
      if (t > CODE_MID) t = CODE_MID;
      code = n < 0 ? CODE_MID - longint'(t) : CODE_MID + longint'(t);
      if (code < 0) code = 0;
      if (code > 4095) code = 4095;
      return code[CODE_BITS-1:0];
    endfunction

    function void note_key(raw_key_t k);
      logic [127:0] len2;
      longint key [4];
      longint mag [4];
      longint dot, big_abs, a;
      logic flip;
      int big, slot;
      logic [CODE_BITS-1:0] codes [3];
      packed_key_t p;
      len2 = 0;
      for (int i = 0; i < 4; i++) begin
        mag[i] = k.c[i] < 0 ? -longint'(k.c[i]) : longint'(k.c[i]);
        len2 += 128'(mag[i]) * 128'(mag[i]);
      end
      if (len2 == 0) begin
        key = '{0, 0, 0, longint'(1) << FB};
      end else begin
        for (int i = 0; i < 4; i++) begin
          key[i] = unit_mag(mag[i], len2);
          if (k.c[i] < 0) key[i] = -key[i];
        end
      end
      if (k.first) begin
        flip = key[3] < 0;
      end else begin
        dot = 0;
        for (int i = 0; i < 4; i++) dot += prev_key[i] * key[i];
        flip = dot < 0;
      end
      for (int i = 0; i < 4; i++) begin
        if (flip) key[i] = -key[i];
        prev_key[i] = key[i];
      end
      big = 0;
      big_abs = key[0] < 0 ? -key[0] : key[0];
      for (int i = 1; i < 4; i++) begin
        a = key[i] < 0 ? -key[i] : key[i];
        if (a > big_abs) begin
          big = i;
          big_abs = a;
        end
      end
      slot = 0;
      for (int i = 0; i < 4; i++) begin
        if (i != big) begin
          codes[slot] = code_for(key[i]);
          slot++;
        end
      end
      p.word = '0;
      p.word[11:0]  = codes[0];
      p.word[23:12] = codes[1];
      p.word[35:24] = codes[2];
      p.word[37:36] = big[1:0];
      p.word[38]    = key[big] < 0;
      p.flip = flip;
      pending_words.insert(pending_words.size(), p);
    endfunction

    function void check_word(logic [PACK_BITS-1:0] word, logic flip);
      packed_key_t e;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word %h flip %b", word, flip);
        return;
      end
      e = pending_words.pop_front();
      if (word !== e.word || flip !== e.flip) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected word %h flip %b, got word %h flip %b",
                   e.word, e.flip, word, flip);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [IB-1:0] comp_x, comp_y, comp_z, comp_w;
  logic                 first_key;
  logic                 out_valid;
  logic                 out_stall;
  logic [PACK_BITS-1:0] packed_word;
  logic                 flipped;

  quaternion_hemisphere_pack40 DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .comp_x(comp_x), .comp_y(comp_y), .comp_z(comp_z), .comp_w(comp_w),
    .first_key(first_key),
    .out_valid(out_valid), .out_stall(out_stall),
    .packed_word(packed_word), .flipped(flipped)
  );

  key_scoreboard sb = new();

  int send_idle_pct = 0;    // chance per cycle that the sender stays idle
  int stall_pct = 0;        // chance per cycle that the receiver stalls
  int hold_req = 0;         // long receiver hold-off requested, in cycles
  int hold_left = 0;
  int quiet_cycles = 0;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Receiver: random stalls, plus one long hold-off on request so the
  // output register and the core both fill and the input backs up.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_req > 0 || hold_left > 0) begin
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= $urandom_range(0, 99) < stall_pct;
    end
  end

  // Result checker and watchdog; both read the values from before the edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_word(packed_word, flipped);
      if ((out_valid && !out_stall) || (in_valid && !in_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("quaternion_hemisphere_pack40_tb: errors");
        $finish;
      end
    end
  end

  // Offers one word, with random idle cycles ahead of it, and holds it
  // until it is taken. Leaves in_valid high so back-to-back words do not
  // toggle it within one step.
  task automatic send_key(raw_key_t k);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    comp_x    <= k.c[0];
    comp_y    <= k.c[1];
    comp_z    <= k.c[2];
    comp_w    <= k.c[3];
    first_key <= k.first;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sb.note_key(k);
  endtask

  task automatic send_raw(int x, int y, int z, int w, logic first);
    raw_key_t k;
    k.c[0] = x[IB-1:0];
    k.c[1] = y[IB-1:0];
    k.c[2] = z[IB-1:0];
    k.c[3] = w[IB-1:0];
    k.first = first;
    send_key(k);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk);
  endtask

  // Mostly runs of smoothly varying keys so the dot decides the flip, with
  // sign jumps, tiny and full-scale noise mixed in.
  function automatic raw_key_t random_key(ref raw_key_t last);
    raw_key_t k;
    int pick, d;
    pick = $urandom_range(0, 9);
    k.first = $urandom_range(0, 7) == 0;
    for (int i = 0; i < 4; i++) begin
      case (pick)
        0, 1: k.c[i] = IB'($urandom);
        2: k.c[i] = IB'($signed($urandom_range(0, 6)) - 3);
        3: k.c[i] = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        default: begin
          d = $signed($urandom_range(0, 4000)) - 2000;
          k.c[i] = last.c[i] + d[IB-1:0];
          if (pick == 9 && $urandom_range(0, 1)) k.c[i] = -k.c[i];
        end
      endcase
    end
    last = k;
    return k;
  endfunction

  initial begin
    raw_key_t last;
    int pct_sets [4][2] = '{'{0, 0}, '{79, 0}, '{0, 79}, '{15, 15}};
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    comp_x    <= '0;
    comp_y    <= '0;
    comp_z    <= '0;
    comp_w    <= '0;
    first_key <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: continuing key straight after reset (zero previous key)
    send_raw(0, 0, 0, -16384, 0);
    send_raw(0, 0, 0, 0, 1);                 // zero length on a run start
    send_raw(0, 0, 0, 0, 0);                 // zero length continuing
    send_raw(0, 0, 0, -16384, 1);            // negative w starts a run
    send_raw(16384, 0, 0, 0, 0);             // orthogonal: dot is zero
    send_raw(-16384, 0, 0, 0, 0);            // opposite: flipped
    send_raw(-32768, -32768, -32768, -32768, 1);
    send_raw(32767, 32767, 32767, 32767, 0);
    send_raw(-32768, 32767, -32768, 32767, 1);
    send_raw(32767, -32768, 32767, -32768, 0);
    send_raw(-32768, -32768, -32768, -1, 1); // tiny negative w
    send_raw(1, 0, 0, 0, 1);
    send_raw(0, -1, 0, 0, 0);
    send_raw(0, 0, 1, 0, 0);
    send_raw(100, 100, 100, 100, 1);         // equal magnitudes: lowest index
    send_raw(-100, 100, -100, 100, 0);
    send_raw(11585, 11585, 0, 0, 1);         // near the 1/sqrt(2) clamp
    send_raw(-11585, 0, 11586, 0, 0);
    send_raw(1, 2, 3, 32767, 0);
    send_raw(-21845, 5461, -12000, 4000, 0);

    // hold the receiver off while words keep coming, then pause until done
    hold_req = LONG_HOLD;
    last = '{c: '{0, 0, 0, 16384}, first: 1'b1};
    for (int n = 0; n < 6; n++) send_key(random_key(last));
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      send_idle_pct = pct_sets[ph % 4][0];
      stall_pct     = pct_sets[ph % 4][1];
      for (int n = 0; n < 275; n++) send_key(random_key(last));
    end
    drain();
    repeat (300) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending_words.size() == 0)
      $display("quaternion_hemisphere_pack40_tb: clean");
    else
      $display("quaternion_hemisphere_pack40_tb: errors");
    $finish;
  end

endmodule
